@@ src/tama_pkg.sv @@
`default_nettype none

package tama_pkg;

    localparam int MAX_WINDOW   = 16;
    localparam int SAMPLE_W     = 16;
    localparam int WIN_REG_W    = 5;
    localparam logic [WIN_REG_W-1:0] WINDOW_RESET = 5'd10;

    localparam int POS_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int WIN_W = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W = SAMPLE_W + $clog2(MAX_WINDOW) + 1;
    localparam int DIV_CNT_W = $clog2(SUM_W + 1);

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [SUM_W-1:0]    t_sum;
    typedef logic [WIN_W-1:0]           t_win;
    typedef logic [POS_W-1:0]           t_pos;

    function automatic t_win eff_window(input logic [WIN_REG_W-1:0] win_reg);
        t_win w;
        if (win_reg == '0) begin
            w = t_win'(1);
        end else if (int'(win_reg) > MAX_WINDOW) begin
            w = t_win'(MAX_WINDOW);
        end else begin
            w = t_win'(win_reg);
        end
        return w;
    endfunction

endpackage

`default_nettype wire

@@ src/tama_div.sv @@
`default_nettype none

module tama_div (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_start,
    input  tama_pkg::t_sum        i_dividend,
    input  tama_pkg::t_win        i_divisor,
    output logic                  o_done,
    output tama_pkg::t_sample     o_quotient
);

    localparam int SUM_W = tama_pkg::SUM_W;
    localparam int WIN_W = tama_pkg::WIN_W;
    localparam int CNT_W = tama_pkg::DIV_CNT_W;

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [SUM_W-1:0]     r_quo;
    logic [WIN_W-1:0]     r_rem;
    logic [WIN_W-1:0]     r_dvs;
    logic                 r_neg;
    tama_pkg::t_sample    r_quotient;

    logic [WIN_W:0]       trial;
    logic                 ge;
    logic [WIN_W-1:0]     n_rem;
    logic [SUM_W-1:0]     n_quo;
    logic [SUM_W-1:0]     signed_quo;

    always_comb begin
        trial = {r_rem, r_quo[SUM_W-1]};
        ge    = (trial >= {1'b0, r_dvs});
        if (ge) begin
            n_rem = WIN_W'(trial - {1'b0, r_dvs});
        end else begin
            n_rem = WIN_W'(trial);
        end
        n_quo      = {r_quo[SUM_W-2:0], ge};
        signed_quo = r_neg ? (~n_quo + SUM_W'(1)) : n_quo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(SUM_W);
                r_rem  <= '0;
                r_dvs  <= i_divisor;
                r_neg  <= i_dividend[SUM_W-1];
                r_quo  <= i_dividend[SUM_W-1] ? SUM_W'(-i_dividend) : SUM_W'(i_dividend);
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy     <= 1'b0;
                    r_done     <= 1'b1;
                    r_quotient <= tama_pkg::t_sample'(signed_quo[tama_pkg::SAMPLE_W-1:0]);
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quotient;

endmodule

`default_nettype wire

@@ src/three_axis_moving_average.sv @@
`default_nettype none

// Channel    Direction  Signals                          Contents
// s_axis     in         s_axis_tvalid/tready/tdata[47:0] accel_x, accel_y, accel_z
// m_axis     out        m_axis_tvalid/tready/tdata[47:0] mean_x, mean_y, mean_z
// cfg        in         i_cfg_wen, i_cfg_wdata[4:0]      window_length
//
// Each accepted item passes through the update state, then the 21-step serial
// divider run once per axis (each run with its start and done strobes), then one
// output load; the next item is accepted only after that load.
// s_axis_tready is high only while the sequencer is idle.
// A finished item waits in the output register; the next item is taken meanwhile.
// Reset and window writes clear the rings (through per-entry valid bits), sums
// and write position at once; a window write in the update state loses to that update.

module three_axis_moving_average (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [47:0] s_axis_tdata,   // accel_x [15:0], accel_y [31:16], accel_z [47:32]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [47:0] m_axis_tdata,   // mean_x [15:0], mean_y [31:16], mean_z [47:32]
    input  wire         i_cfg_wen,
    input  wire  [4:0]  i_cfg_wdata
);

    localparam int MAXW  = tama_pkg::MAX_WINDOW;
    localparam int SMP_W = tama_pkg::SAMPLE_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPD,
        S_DIV,
        S_WAIT,
        S_OUT
    } t_state;

    t_state                    r_state;
    logic [tama_pkg::WIN_REG_W-1:0] r_win_reg;
    tama_pkg::t_pos            r_pos;
    logic [MAXW-1:0]           r_valid;
    logic [3*SMP_W-1:0]        r_ring [MAXW];
    tama_pkg::t_sum            r_sum [3];
    tama_pkg::t_sample         r_smp [3];
    tama_pkg::t_sample         r_mean [3];
    logic [1:0]                r_axis;
    logic                      r_start;
    logic                      r_m_valid;
    logic [3*SMP_W-1:0]        r_m_data;

    tama_pkg::t_win            win;
    tama_pkg::t_pos            pos_eff;
    tama_pkg::t_pos            n_pos;
    logic [3*SMP_W-1:0]        old_entry;
    tama_pkg::t_sum            n_sum [3];
    logic                      div_done;
    tama_pkg::t_sample         div_quo;

    always_comb begin
        win = tama_pkg::eff_window(r_win_reg);
        if (int'(r_pos) >= int'(win)) begin
            pos_eff = '0;
        end else begin
            pos_eff = r_pos;
        end
        if (int'(pos_eff) + 1 >= int'(win)) begin
            n_pos = '0;
        end else begin
            n_pos = pos_eff + tama_pkg::t_pos'(1);
        end
        old_entry = r_valid[pos_eff] ? r_ring[pos_eff] : '0;
        for (int a = 0; a < 3; a++) begin
            n_sum[a] = r_sum[a]
                     - tama_pkg::t_sum'($signed(old_entry[a*SMP_W +: SMP_W]))
                     + tama_pkg::t_sum'(r_smp[a]);
        end
    end

    tama_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_start),
        .i_dividend (r_sum[r_axis]),
        .i_divisor  (win),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_win_reg <= tama_pkg::WINDOW_RESET;
            r_pos     <= '0;
            r_valid   <= '0;
            r_sum[0]  <= '0;
            r_sum[1]  <= '0;
            r_sum[2]  <= '0;
            r_axis    <= '0;
            r_start   <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_start <= 1'b0;
            if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            if (i_cfg_wen) begin
                r_win_reg <= i_cfg_wdata;
                r_pos     <= '0;
                r_valid   <= '0;
                r_sum[0]  <= '0;
                r_sum[1]  <= '0;
                r_sum[2]  <= '0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_smp[0] <= tama_pkg::t_sample'(s_axis_tdata[15:0]);
                        r_smp[1] <= tama_pkg::t_sample'(s_axis_tdata[31:16]);
                        r_smp[2] <= tama_pkg::t_sample'(s_axis_tdata[47:32]);
                        r_state  <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_ring[pos_eff]  <= {r_smp[2], r_smp[1], r_smp[0]};
                    r_valid[pos_eff] <= 1'b1;
                    r_sum[0]         <= n_sum[0];
                    r_sum[1]         <= n_sum[1];
                    r_sum[2]         <= n_sum[2];
                    r_pos            <= n_pos;
                    r_axis           <= '0;
                    r_state          <= S_DIV;
                end
                S_DIV: begin
                    r_start <= 1'b1;
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (div_done) begin
                        r_mean[r_axis] <= div_quo;
                        if (r_axis == 2'd2) begin
                            r_state <= S_OUT;
                        end else begin
                            r_axis  <= r_axis + 2'd1;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_OUT: begin
                    if (!r_m_valid || m_axis_tready) begin
                        r_m_data  <= {r_mean[2], r_mean[1], r_mean[0]};
                        r_m_valid <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule

`default_nettype wire
